// File: src/dqo_pkg.sv
// dqo_pkg: shared types and constants of the dual quadrature odometer
// request codes, lane control bundle and field widths
// no dependencies
package dqo_pkg;

  // default decoded count width
  localparam int COUNT_WIDTH_DEF = 32;

  // widths of the reported fields
  localparam int POS_W  = 32;
  localparam int SUM_W  = 33;
  localparam int DIST_W = 34;

  // packed stream widths
  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 264;

  // request kinds carried on the input tuser
  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_TICK   = 2'd1,
    REQ_LOAD   = 2'd2,
    REQ_CLEAR  = 2'd3
  } dqo_req_t;

  // per-transfer control toward each wheel lane
  typedef struct packed {
    logic sample;
    logic tick;
    logic clear;
  } dqo_lane_ctl_t;

endpackage

// File: src/dqo_lane.sv
// dqo_lane: x4 quadrature decoder and tick sampler for one wheel
// holds the previous pin levels, the count and the count at the last tick
// depends on dqo_pkg
module dqo_lane #(
  parameter int CW     = dqo_pkg::COUNT_WIDTH_DEF,
  parameter bit MIRROR = 1'b0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  dqo_pkg::dqo_lane_ctl_t ctl,
  input  logic [1:0]            pins,     // bit1 = A, bit0 = B
  output logic [CW-1:0]         pos,
  output logic [CW-1:0]         sampled,
  output logic [CW-1:0]         delta,
  output logic                  err
);

  logic [1:0]    pins_prev;
  logic [CW-1:0] count;
  logic [CW-1:0] count_at_tick;

  logic [1:0]    chg;
  logic          pin_a;
  logic          pin_b;
  logic          up;
  logic          both_changed;
  logic [CW-1:0] count_step;
  logic [CW-1:0] count_next;
  logic [CW-1:0] sampled_next;

  // direction of a single pin change
  always_comb begin
    chg          = pins_prev ^ pins;
    pin_a        = pins[1];
    pin_b        = pins[0];
    both_changed = (chg == 2'b11);
    if (chg == 2'b10) begin
      up = MIRROR ? (pin_a != pin_b) : (pin_a == pin_b);
    end else begin
      up = MIRROR ? (pin_a == pin_b) : (pin_a != pin_b);
    end
    if (chg == 2'b00 || both_changed) begin
      count_step = count;
    end else if (up) begin
      count_step = count + CW'(1);
    end else begin
      count_step = count - CW'(1);
    end
  end

  // state after this transfer
  always_comb begin
    count_next   = count;
    sampled_next = count_at_tick;
    if (ctl.sample) begin
      count_next = count_step;
    end
    if (ctl.tick) begin
      sampled_next = count;
    end
    if (ctl.clear) begin
      count_next   = '0;
      sampled_next = '0;
    end
  end

  // wheel state, changed only by accepted sample, tick and clear transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      pins_prev     <= 2'b00;
      count         <= '0;
      count_at_tick <= '0;
    end else begin
      if (ctl.sample) begin
        pins_prev <= pins;
      end
      count         <= count_next;
      count_at_tick <= sampled_next;
    end
  end

  // first pipeline stage toward the merge
  always_ff @(posedge clk) begin
    if (advance) begin
      pos     <= count_next;
      sampled <= sampled_next;
      delta   <= ctl.tick ? (count - count_at_tick) : '0;
      err     <= ctl.sample && both_changed;
    end
  end

endmodule

// File: src/dqo_merge.sv
// dqo_merge: combines both wheel lanes into the odometry result
// keeps the remaining forward and rotation distances, registers the result
// depends on dqo_pkg
module dqo_merge #(
  parameter int CW = dqo_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          in_valid,
  input  dqo_pkg::dqo_req_t             req,
  input  logic [dqo_pkg::DIST_W-1:0]    target_x_half,
  input  logic [dqo_pkg::DIST_W-1:0]    target_w,
  input  logic [CW-1:0]                 l_pos,
  input  logic [CW-1:0]                 r_pos,
  input  logic [CW-1:0]                 l_sampled,
  input  logic [CW-1:0]                 r_sampled,
  input  logic [CW-1:0]                 l_delta,
  input  logic [CW-1:0]                 r_delta,
  input  logic                          l_err,
  input  logic                          r_err,
  output logic [dqo_pkg::POS_W-1:0]     left_position,
  output logic [dqo_pkg::POS_W-1:0]     right_position,
  output logic [dqo_pkg::POS_W-1:0]     left_delta,
  output logic [dqo_pkg::POS_W-1:0]     right_delta,
  output logic [dqo_pkg::SUM_W-1:0]     forward_sum,
  output logic [dqo_pkg::SUM_W-1:0]     rotation_count,
  output logic [dqo_pkg::DIST_W-1:0]    remaining_x_half,
  output logic [dqo_pkg::DIST_W-1:0]    remaining_w,
  output logic                          pin_error
);

  localparam int PW = dqo_pkg::POS_W;
  localparam int SW = dqo_pkg::SUM_W;
  localparam int DW = dqo_pkg::DIST_W;

  logic [DW-1:0] rem_fwd;
  logic [DW-1:0] rem_rot;
  logic [DW-1:0] rem_fwd_next;
  logic [DW-1:0] rem_rot_next;
  logic [DW-1:0] l_delta_x;
  logic [DW-1:0] r_delta_x;

  // sign-extended deltas for the distance update
  assign l_delta_x = DW'(signed'(l_delta));
  assign r_delta_x = DW'(signed'(r_delta));

  // remaining distances after this transfer
  always_comb begin
    rem_fwd_next = rem_fwd;
    rem_rot_next = rem_rot;
    case (req)
      dqo_pkg::REQ_SAMPLE: begin
      end
      dqo_pkg::REQ_TICK: begin
        rem_fwd_next = rem_fwd - (l_delta_x + r_delta_x);
        rem_rot_next = rem_rot - (r_delta_x - l_delta_x);
      end
      dqo_pkg::REQ_LOAD: begin
        rem_fwd_next = target_x_half;
        rem_rot_next = target_w;
      end
      dqo_pkg::REQ_CLEAR: begin
        rem_fwd_next = '0;
        rem_rot_next = '0;
      end
      default: begin
      end
    endcase
  end

  // distance state
  always_ff @(posedge clk) begin
    if (rst) begin
      rem_fwd <= '0;
      rem_rot <= '0;
    end else if (advance && in_valid) begin
      rem_fwd <= rem_fwd_next;
      rem_rot <= rem_rot_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      left_position    <= PW'(signed'(l_pos));
      right_position   <= PW'(signed'(r_pos));
      left_delta       <= PW'(signed'(l_delta));
      right_delta      <= PW'(signed'(r_delta));
      forward_sum      <= SW'(signed'(l_sampled)) + SW'(signed'(r_sampled));
      rotation_count   <= SW'(signed'(r_sampled)) - SW'(signed'(l_sampled));
      remaining_x_half <= rem_fwd_next;
      remaining_w      <= rem_rot_next;
      pin_error        <= l_err | r_err;
    end
  end

endmodule

// File: src/dual_quadrature_odometer_top.sv
// Path: lane and stage-A registers, then the merge result register (m_tvalid).
// Throughput: one item per cycle unless stalled; counts change on sample/clear.
// Stalls: the whole two-stage pipeline holds while a result waits on m_tready.
// Reset: synchronous, active high; clears counts, pin history and distances.
// Holds the two wheel lanes and the merge stage; depends on dqo_pkg,
// dqo_lane and dqo_merge.
module dual_quadrature_odometer_top #(
  parameter int COUNT_WIDTH = dqo_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // left_a, left_b, right_a, right_b, target_x_half, target_w
  input  logic [dqo_pkg::IN_DATA_W-1:0]   s_tdata,
  // req_type
  input  logic [dqo_pkg::IN_USER_W-1:0]   s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // left_position, right_position, left_delta, right_delta, forward_sum,
  // rotation_count, remaining_x_half, remaining_w, pin_error, zero pad
  output logic [dqo_pkg::OUT_DATA_W-1:0]  m_tdata
);

  localparam int DW = dqo_pkg::DIST_W;

  logic                   advance;
  logic                   accept;
  dqo_pkg::dqo_req_t      req;
  dqo_pkg::dqo_lane_ctl_t lane_ctl;

  logic                   a_valid;
  dqo_pkg::dqo_req_t      a_req;
  logic [DW-1:0]          a_tx;
  logic [DW-1:0]          a_tw;

  logic [COUNT_WIDTH-1:0] l_pos, r_pos, l_samp, r_samp, l_dlt, r_dlt;
  logic                   l_err, r_err;

  logic [dqo_pkg::POS_W-1:0]  left_position, right_position;
  logic [dqo_pkg::POS_W-1:0]  left_delta, right_delta;
  logic [dqo_pkg::SUM_W-1:0]  forward_sum, rotation_count;
  logic [DW-1:0]              remaining_x_half, remaining_w;
  logic                       pin_error;

  // pipeline moves when the result register is free or being drained
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;
  assign accept   = s_tvalid && advance;
  assign req      = dqo_pkg::dqo_req_t'(s_tuser);

  // lane control per request kind
  always_comb begin
    lane_ctl.sample = accept && (req == dqo_pkg::REQ_SAMPLE);
    lane_ctl.tick   = accept && (req == dqo_pkg::REQ_TICK);
    lane_ctl.clear  = accept && (req == dqo_pkg::REQ_CLEAR);
  end

  // stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      a_valid  <= accept;
      m_tvalid <= a_valid;
    end
  end

  // first stage payload for the merge
  always_ff @(posedge clk) begin
    if (advance) begin
      a_req <= req;
      a_tx  <= s_tdata[37:4];
      a_tw  <= s_tdata[71:38];
    end
  end

  // left wheel lane
  dqo_lane #(
    .CW     (COUNT_WIDTH),
    .MIRROR (1'b0)
  ) u_left (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .ctl     (lane_ctl),
    .pins    ({s_tdata[0], s_tdata[1]}),
    .pos     (l_pos),
    .sampled (l_samp),
    .delta   (l_dlt),
    .err     (l_err)
  );

  // right wheel lane, mirrored direction rule
  dqo_lane #(
    .CW     (COUNT_WIDTH),
    .MIRROR (1'b1)
  ) u_right (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .ctl     (lane_ctl),
    .pins    ({s_tdata[2], s_tdata[3]}),
    .pos     (r_pos),
    .sampled (r_samp),
    .delta   (r_dlt),
    .err     (r_err)
  );

  // merge of both lanes
  dqo_merge #(
    .CW (COUNT_WIDTH)
  ) u_merge (
    .clk              (clk),
    .rst              (rst),
    .advance          (advance),
    .in_valid         (a_valid),
    .req              (a_req),
    .target_x_half    (a_tx),
    .target_w         (a_tw),
    .l_pos            (l_pos),
    .r_pos            (r_pos),
    .l_sampled        (l_samp),
    .r_sampled        (r_samp),
    .l_delta          (l_dlt),
    .r_delta          (r_dlt),
    .l_err            (l_err),
    .r_err            (r_err),
    .left_position    (left_position),
    .right_position   (right_position),
    .left_delta       (left_delta),
    .right_delta      (right_delta),
    .forward_sum      (forward_sum),
    .rotation_count   (rotation_count),
    .remaining_x_half (remaining_x_half),
    .remaining_w      (remaining_w),
    .pin_error        (pin_error)
  );

  // result packing, first field in the lowest bits
  assign m_tdata = {1'b0, pin_error, remaining_w, remaining_x_half, rotation_count,
                    forward_sum, right_delta, left_delta, right_position,
                    left_position};

endmodule

// File: src/dqo_checker.sv
// dqo_checker: port-level checks of the dual quadrature odometer
// bound to dual_quadrature_odometer_top; depends on dqo_pkg
module dqo_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [dqo_pkg::OUT_DATA_W-1:0]  m_tdata
);

  // no result right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // input side never stalls while the output drains
  assert property (@(posedge clk) disable iff (rst) m_tready |-> s_tready)
    else $error("input stalled while output ready");

  // a transfer reaches the output through both pipeline registers when not stalled
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
    else $error("result missing after transfer");

  // a stalled result holds its value
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind dual_quadrature_odometer_top dqo_checker u_dqo_checker (.*);

// File: tb/sv/tb_dual_quadrature_odometer_top.sv
// tb_dual_quadrature_odometer_top: self-checking bench for the two-wheel x4 odometer
// drives sample, tick, load and clear transfers and checks every result against a local model
// depends on dqo_pkg and dual_quadrature_odometer_top
`timescale 1ns / 1ps

module tb_dual_quadrature_odometer_top;

  localparam int POS_W      = dqo_pkg::POS_W;
  localparam int SUM_W      = dqo_pkg::SUM_W;
  localparam int DIST_W     = dqo_pkg::DIST_W;
  localparam int IN_DATA_W  = dqo_pkg::IN_DATA_W;
  localparam int IN_USER_W  = dqo_pkg::IN_USER_W;
  localparam int OUT_DATA_W = dqo_pkg::OUT_DATA_W;

  localparam int QUIET_LIMIT = 3000;
  localparam int LONG_HOLD   = 60;
  localparam int PHASE_ITEMS = 360;
  localparam int PRINT_CAP   = 40;

  localparam logic [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  // one request as it goes on the input stream; pins are {rb, ra, lb, la}
  typedef struct packed {
    dqo_pkg::dqo_req_t req;
    logic [3:0]        pins;
    logic [DIST_W-1:0] target_x;
    logic [DIST_W-1:0] target_w;
  } odo_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  left_position;
    logic [POS_W-1:0]  right_position;
    logic [POS_W-1:0]  left_delta;
    logic [POS_W-1:0]  right_delta;
    logic [SUM_W-1:0]  forward_sum;
    logic [SUM_W-1:0]  rotation_count;
    logic [DIST_W-1:0] remaining_x;
    logic [DIST_W-1:0] remaining_w;
    logic              pin_error;
  } odo_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [IN_USER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  dual_quadrature_odometer_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // model state of the odometer
  logic [1:0]        left_pins_was  = '0;
  logic [1:0]        right_pins_was = '0;
  logic [POS_W-1:0]  left_count     = '0;
  logic [POS_W-1:0]  right_count    = '0;
  logic [POS_W-1:0]  left_at_tick   = '0;
  logic [POS_W-1:0]  right_at_tick  = '0;
  logic [DIST_W-1:0] forward_to_go  = '0;
  logic [DIST_W-1:0] rotation_to_go = '0;

  odo_item_t   pending_items[$];
  odo_result_t expected_results[$];
  odo_item_t   offered;
  logic [3:0]  gen_pins = '0;
  bit          in_fire = 1'b0;
  bit          long_hold_due = 1'b0;
  int          hold_left = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          mismatch_count = 0;
  int          quiet_cycles = 0;

  // x4 decode of one wheel: returns {both pins changed, new count}
  function automatic logic [POS_W:0] wheel_step(logic [POS_W-1:0] cnt, logic [1:0] was,
                                                logic [1:0] now, bit mirror);
    logic [1:0] chg;
    logic       a;
    logic       b;
    logic       up;
    chg = was ^ now;
    a   = now[1];
    b   = now[0];
    if (chg == 2'b00) return {1'b0, cnt};
    if (chg == 2'b11) return {1'b1, cnt};
    if (chg == 2'b10) up = mirror ? (a != b) : (a == b);
    else up = mirror ? (a == b) : (a != b);
    return {1'b0, up ? cnt + POS_W'(1) : cnt - POS_W'(1)};
  endfunction

  // advance the odometer by one request and form its result
  function automatic odo_result_t odometry_step(odo_item_t it);
    odo_result_t       r;
    logic [POS_W:0]    lw;
    logic [POS_W:0]    rw;
    logic [POS_W-1:0]  ld;
    logic [POS_W-1:0]  rd;
    logic [DIST_W-1:0] ld_x;
    logic [DIST_W-1:0] rd_x;
    ld = '0;
    rd = '0;
    r.pin_error = 1'b0;
    case (it.req)
      dqo_pkg::REQ_SAMPLE: begin
        lw = wheel_step(left_count, left_pins_was, {it.pins[0], it.pins[1]}, 1'b0);
        rw = wheel_step(right_count, right_pins_was, {it.pins[2], it.pins[3]}, 1'b1);
        left_count     = lw[POS_W-1:0];
        right_count    = rw[POS_W-1:0];
        r.pin_error    = lw[POS_W] | rw[POS_W];
        left_pins_was  = {it.pins[0], it.pins[1]};
        right_pins_was = {it.pins[2], it.pins[3]};
      end
      dqo_pkg::REQ_TICK: begin
        ld   = left_count - left_at_tick;
        rd   = right_count - right_at_tick;
        ld_x = {{(DIST_W-POS_W){ld[POS_W-1]}}, ld};
        rd_x = {{(DIST_W-POS_W){rd[POS_W-1]}}, rd};
        left_at_tick   = left_count;
        right_at_tick  = right_count;
        forward_to_go  = forward_to_go - (ld_x + rd_x);
        rotation_to_go = rotation_to_go - (rd_x - ld_x);
      end
      dqo_pkg::REQ_LOAD: begin
        forward_to_go  = it.target_x;
        rotation_to_go = it.target_w;
      end
      default: begin
        left_count     = '0;
        right_count    = '0;
        left_at_tick   = '0;
        right_at_tick  = '0;
        forward_to_go  = '0;
        rotation_to_go = '0;
      end
    endcase
    r.left_position  = left_count;
    r.right_position = right_count;
    r.left_delta     = ld;
    r.right_delta    = rd;
    r.forward_sum    = {left_at_tick[POS_W-1], left_at_tick}
                     + {right_at_tick[POS_W-1], right_at_tick};
    r.rotation_count = {right_at_tick[POS_W-1], right_at_tick}
                     - {left_at_tick[POS_W-1], left_at_tick};
    r.remaining_x    = forward_to_go;
    r.remaining_w    = rotation_to_go;
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic queue_item(dqo_pkg::dqo_req_t req, logic [3:0] pins,
                            logic [DIST_W-1:0] tx, logic [DIST_W-1:0] tw);
    odo_item_t it;
    it.req      = req;
    it.pins     = pins;
    it.target_x = tx;
    it.target_w = tw;
    pending_items.push_back(it);
    if (req == dqo_pkg::REQ_SAMPLE) gen_pins = pins;
  endtask

  // hold the sender back until every queued request has its result
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0);
    @(posedge clk);
  endtask

  // input driver: next request at the falling edge once the previous one is taken
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || in_fire)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offered = pending_items.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {offered.target_w, offered.target_x, offered.pins};
        s_tuser  <= offered.req;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (long_hold_due) begin
        long_hold_due = 1'b0;
        hold_left = LONG_HOLD;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // monitor: predict on input transfers, check output transfers, watch for a hang
  always @(posedge clk) begin
    odo_result_t got;
    odo_result_t want;
    if (!rst) begin
      in_fire = s_tvalid && s_tready;
      if (in_fire) expected_results.push_back(odometry_step(offered));
      if (m_tvalid && m_tready) begin
        got.left_position  = m_tdata[31:0];
        got.right_position = m_tdata[63:32];
        got.left_delta     = m_tdata[95:64];
        got.right_delta    = m_tdata[127:96];
        got.forward_sum    = m_tdata[160:128];
        got.rotation_count = m_tdata[193:161];
        got.remaining_x    = m_tdata[227:194];
        got.remaining_w    = m_tdata[261:228];
        got.pin_error      = m_tdata[262];
        if (expected_results.size() == 0) begin
          flag_mismatch("result with nothing expected", m_tdata[63:0], '0);
        end else begin
          want = expected_results.pop_front();
          if (got.left_position !== want.left_position)
            flag_mismatch("left_position", 64'(got.left_position),
                          64'(want.left_position));
          if (got.right_position !== want.right_position)
            flag_mismatch("right_position", 64'(got.right_position),
                          64'(want.right_position));
          if (got.left_delta !== want.left_delta)
            flag_mismatch("left_delta", 64'(got.left_delta), 64'(want.left_delta));
          if (got.right_delta !== want.right_delta)
            flag_mismatch("right_delta", 64'(got.right_delta), 64'(want.right_delta));
          if (got.forward_sum !== want.forward_sum)
            flag_mismatch("forward_sum", 64'(got.forward_sum), 64'(want.forward_sum));
          if (got.rotation_count !== want.rotation_count)
            flag_mismatch("rotation_count", 64'(got.rotation_count),
                          64'(want.rotation_count));
          if (got.remaining_x !== want.remaining_x)
            flag_mismatch("remaining_x_half", 64'(got.remaining_x), 64'(want.remaining_x));
          if (got.remaining_w !== want.remaining_w)
            flag_mismatch("remaining_w", 64'(got.remaining_w), 64'(want.remaining_w));
          if (got.pin_error !== want.pin_error)
            flag_mismatch("pin_error", 64'(got.pin_error), 64'(want.pin_error));
        end
      end
      if (in_fire || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // stimulus sequence
  initial begin
    int                k;
    logic [3:0]        pins;
    logic [1:0]        flip;
    logic [DIST_W-1:0] tx;
    logic [DIST_W-1:0] tw;
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(posedge clk);

    // directed: single steps both ways, double changes, load extremes, clear
    queue_item(dqo_pkg::REQ_SAMPLE, 4'b0000, '0, '0);
    queue_item(dqo_pkg::REQ_SAMPLE, 4'b0001, '0, '0);
    queue_item(dqo_pkg::REQ_SAMPLE, 4'b0011, '0, '0);
    queue_item(dqo_pkg::REQ_SAMPLE, 4'b0111, '0, '0);
    queue_item(dqo_pkg::REQ_SAMPLE, 4'b1111, '0, '0);
    queue_item(dqo_pkg::REQ_TICK,   4'b0000, DIST_MAX, DIST_MAX);
    queue_item(dqo_pkg::REQ_SAMPLE, 4'b0000, '0, '0);
    queue_item(dqo_pkg::REQ_SAMPLE, 4'b0011, '0, '0);
    queue_item(dqo_pkg::REQ_SAMPLE, 4'b1111, '0, '0);
    queue_item(dqo_pkg::REQ_TICK,   4'b1010, '0, '0);
    queue_item(dqo_pkg::REQ_LOAD,   4'b0101, DIST_MAX, DIST_MIN);
    queue_item(dqo_pkg::REQ_TICK,   4'b0000, '0, '0);
    queue_item(dqo_pkg::REQ_LOAD,   4'b1010, DIST_MIN, DIST_MAX);
    queue_item(dqo_pkg::REQ_SAMPLE, 4'b1110, '0, '0);
    queue_item(dqo_pkg::REQ_SAMPLE, 4'b1100, '0, '0);
    queue_item(dqo_pkg::REQ_TICK,   4'b1111, '0, '0);
    queue_item(dqo_pkg::REQ_LOAD,   4'b0000, '0, '1);
    queue_item(dqo_pkg::REQ_TICK,   4'b0000, '0, '0);
    queue_item(dqo_pkg::REQ_CLEAR,  4'b0000, '1, '1);
    queue_item(dqo_pkg::REQ_TICK,   4'b0011, '0, '0);
    queue_item(dqo_pkg::REQ_SAMPLE, 4'b1100, '0, '0);
    queue_item(dqo_pkg::REQ_SAMPLE, 4'b1000, '0, '0);
    queue_item(dqo_pkg::REQ_SAMPLE, 4'b1001, '0, '0);
    queue_item(dqo_pkg::REQ_TICK,   4'b0000, '0, '0);
    queue_item(dqo_pkg::REQ_CLEAR,  4'b1111, '0, '0);
    wait_drained();

    // random phases: free flow, sender gaps, receiver stalls, both
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 69 : (phase == 3) ? 34 : 0;
      recv_stall_pct = (phase == 2) ? 69 : (phase == 3) ? 34 : 0;
      if (phase == 0) long_hold_due = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        k  = $urandom_range(99);
        tx = {2'($urandom_range(3)), $urandom()};
        tw = {2'($urandom_range(3)), $urandom()};
        if (k < 72) begin
          // mostly clean quadrature steps, some double changes and noise
          pins = gen_pins;
          if ($urandom_range(19) == 0) begin
            pins = 4'($urandom_range(15));
          end else begin
            for (int w = 0; w < 2; w++) begin
              case ($urandom_range(9))
                0: ;
                9: pins[2*w +: 2] = ~pins[2*w +: 2];
                default: begin
                  flip       = {1'(w), 1'($urandom_range(1))};
                  pins[flip] = ~pins[flip];
                end
              endcase
            end
          end
          queue_item(dqo_pkg::REQ_SAMPLE, pins, tx, tw);
        end else if (k < 88) begin
          queue_item(dqo_pkg::REQ_TICK, 4'($urandom_range(15)), tx, tw);
        end else if (k < 96) begin
          if ($urandom_range(9) == 0) tx = ($urandom_range(1) != 0) ? DIST_MAX : DIST_MIN;
          if ($urandom_range(9) == 0) tw = ($urandom_range(1) != 0) ? DIST_MIN : '1;
          queue_item(dqo_pkg::REQ_LOAD, 4'($urandom_range(15)), tx, tw);
        end else begin
          queue_item(dqo_pkg::REQ_CLEAR, 4'($urandom_range(15)), tx, tw);
        end
      end
      wait_drained();
    end

    // let any stray result show up before the verdict
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
